### sv/jsu_pkg.sv
`default_nettype none

package jsu_pkg;

  // result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // error codes
  localparam logic [2:0] ERR_NO_QUOTE     = 3'd0;
  localparam logic [2:0] ERR_CONTROL      = 3'd1;
  localparam logic [2:0] ERR_BAD_ESCAPE   = 3'd2;
  localparam logic [2:0] ERR_BAD_HEX      = 3'd3;
  localparam logic [2:0] ERR_SURROGATE    = 3'd4;
  localparam logic [2:0] ERR_UNTERMINATED = 3'd5;

  // up to three results caused by one input word, first result in bytes[0]
  typedef struct packed {
    logic [1:0]      cnt;
    logic [1:0]      kind;
    logic [2:0]      err;
    logic [2:0][7:0] bytes;
  } jsu_group_t;

endpackage

`default_nettype wire

### sv/jsu_decoder.sv
`default_nettype none

module jsu_decoder (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire logic [7:0]         in_byte,
  input  wire logic               input_end,
  output jsu_pkg::jsu_group_t     grp
);
  import jsu_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_STR,
    MODE_ESC,
    MODE_HEX
  } mode_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_SPACE = 8'h20;

  mode_t       mode, mode_next;
  logic [1:0]  hex_count, hex_count_next;
  logic [15:0] code_point, code_point_next;

  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [15:0] cp_shift;

  // ascii hex digit to nibble
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  assign {hex_ok, hex_val} = hex_digit(in_byte);
  assign cp_shift = {code_point[11:0], hex_val};

  always_comb begin
    mode_next       = mode;
    hex_count_next  = hex_count;
    code_point_next = code_point;
    grp             = '0;
    if (input_end) begin
      if (mode != MODE_IDLE) begin
        mode_next       = MODE_IDLE;
        hex_count_next  = '0;
        code_point_next = '0;
        grp.cnt         = 2'd1;
        grp.kind        = KIND_ERR;
        grp.err         = ERR_UNTERMINATED;
      end
    end else begin
      unique case (mode)
        MODE_IDLE: begin
          if (in_byte == CH_QUOTE) begin
            mode_next = MODE_STR;
          end else begin
            grp.cnt  = 2'd1;
            grp.kind = KIND_ERR;
            grp.err  = ERR_NO_QUOTE;
          end
        end
        MODE_STR: begin
          grp.cnt = 2'd1;
          if (in_byte == CH_QUOTE) begin
            mode_next = MODE_IDLE;
            grp.kind  = KIND_DONE;
          end else if (in_byte < CH_SPACE) begin
            mode_next       = MODE_IDLE;
            hex_count_next  = '0;
            code_point_next = '0;
            grp.kind        = KIND_ERR;
            grp.err         = ERR_CONTROL;
          end else if (in_byte == CH_BSLASH) begin
            mode_next = MODE_ESC;
            grp.cnt   = 2'd0;
          end else begin
            grp.kind     = KIND_DATA;
            grp.bytes[0] = in_byte;
          end
        end
        MODE_ESC: begin
          grp.cnt   = 2'd1;
          grp.kind  = KIND_DATA;
          mode_next = MODE_STR;
          case (in_byte)
            CH_QUOTE:  grp.bytes[0] = CH_QUOTE;
            CH_BSLASH: grp.bytes[0] = CH_BSLASH;
            CH_SLASH:  grp.bytes[0] = CH_SLASH;
            8'h62:     grp.bytes[0] = 8'h08;
            8'h66:     grp.bytes[0] = 8'h0c;
            8'h6e:     grp.bytes[0] = 8'h0a;
            8'h72:     grp.bytes[0] = 8'h0d;
            8'h74:     grp.bytes[0] = 8'h09;
            8'h75: begin
              mode_next       = MODE_HEX;
              hex_count_next  = '0;
              code_point_next = '0;
              grp.cnt         = 2'd0;
            end
            default: begin
              mode_next       = MODE_IDLE;
              hex_count_next  = '0;
              code_point_next = '0;
              grp.kind        = KIND_ERR;
              grp.err         = ERR_BAD_ESCAPE;
            end
          endcase
        end
        MODE_HEX: begin
          if (!hex_ok) begin
            mode_next       = MODE_IDLE;
            hex_count_next  = '0;
            code_point_next = '0;
            grp.cnt         = 2'd1;
            grp.kind        = KIND_ERR;
            grp.err         = ERR_BAD_HEX;
          end else if (hex_count != 2'd3) begin
            hex_count_next  = hex_count + 2'd1;
            code_point_next = cp_shift;
          end else if (cp_shift[15:11] == 5'b11011) begin
            // d800..dfff
            mode_next       = MODE_IDLE;
            hex_count_next  = '0;
            code_point_next = '0;
            grp.cnt         = 2'd1;
            grp.kind        = KIND_ERR;
            grp.err         = ERR_SURROGATE;
          end else begin
            mode_next       = MODE_STR;
            hex_count_next  = '0;
            code_point_next = cp_shift;
            grp.kind        = KIND_DATA;
            if (cp_shift[15:7] == '0) begin
              grp.cnt      = 2'd1;
              grp.bytes[0] = cp_shift[7:0];
            end else if (cp_shift[15:11] == '0) begin
              grp.cnt      = 2'd2;
              grp.bytes[0] = {3'b110, cp_shift[10:6]};
              grp.bytes[1] = {2'b10, cp_shift[5:0]};
            end else begin
              grp.cnt      = 2'd3;
              grp.bytes[0] = {4'b1110, cp_shift[15:12]};
              grp.bytes[1] = {2'b10, cp_shift[11:6]};
              grp.bytes[2] = {2'b10, cp_shift[5:0]};
            end
          end
        end
        default: mode_next = MODE_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      hex_count  <= '0;
      code_point <= '0;
    end else if (step) begin
      mode       <= mode_next;
      hex_count  <= hex_count_next;
      code_point <= code_point_next;
    end
  end

endmodule

`default_nettype wire

### sv/json_string_unescape_utf8.sv
// channel  direction  handshake           payload
// in       input      in_valid/in_stall   in_byte[7:0], input_end
// out      output     out_valid/out_stall kind[1:0], data_byte[7:0], error_code[2:0], last
//
// one input word a cycle while not stalled; results pass input, then group register
// a \u escape gives up to three words, one a cycle from the group register unless stalled
// input stalls only while the group register still holds words that are not yet taken
// rst (synchronous) returns the decoder to idle and drops any held words
`default_nettype none

module json_string_unescape_utf8 (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output      logic       in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       input_end,
  output      logic       out_valid,
  input  wire logic       out_stall,
  output      logic [1:0] kind,
  output      logic [7:0] data_byte,
  output      logic [2:0] error_code,
  output      logic       last
);
  import jsu_pkg::*;

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_end;

  // group register: results of one word, head in bytes[0]
  jsu_group_t grp;
  jsu_group_t dec_grp;

  logic in_take;
  logic out_take;
  logic grp_free;
  logic step;

  assign out_take = out_valid && !out_stall;
  // group can take a fresh set once empty or when its final word leaves now
  assign grp_free = (grp.cnt == 2'd0) || (out_take && grp.cnt == 2'd1);
  assign step     = s1_valid && grp_free;
  assign in_stall = s1_valid && !grp_free;
  assign in_take  = in_valid && !in_stall;

  jsu_decoder u_dec (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .in_byte   (s1_byte),
    .input_end (s1_end),
    .grp       (dec_grp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (step) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte <= in_byte;
      s1_end  <= input_end;
    end
  end

  // count is control and is reset, the rest is payload
  always_ff @(posedge clk) begin
    if (rst) begin
      grp.cnt <= '0;
    end else if (step) begin
      grp.cnt <= dec_grp.cnt;
    end else if (out_take) begin
      grp.cnt <= grp.cnt - 2'd1;
    end
    if (step) begin
      grp.kind  <= dec_grp.kind;
      grp.err   <= dec_grp.err;
      grp.bytes <= dec_grp.bytes;
    end else if (out_take) begin
      // shift the next utf-8 byte to the head
      grp.bytes <= {8'h00, grp.bytes[2], grp.bytes[1]};
    end
  end

  assign out_valid  = grp.cnt != 2'd0;
  assign kind       = grp.kind;
  assign data_byte  = grp.bytes[0];
  assign error_code = grp.err;
  assign last       = grp.cnt == 2'd1;

endmodule

`default_nettype wire

### sv/jsu_checker.sv
`default_nettype none

module jsu_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic [7:0] in_byte,
  input wire logic       input_end,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] kind,
  input wire logic [7:0] data_byte,
  input wire logic [2:0] error_code,
  input wire logic       last
);
  import jsu_pkg::*;

  logic unused_in;
  assign unused_in = in_valid ^ in_stall ^ (^in_byte) ^ input_end;

  // held word stays put under stall
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable({kind, data_byte, error_code, last}))
    else $error("output word changed while stalled");

  // done and error words close the set of results
  assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_DATA |-> last && data_byte == 8'h00)
    else $error("done or error word not final or carries data");

  // error code only on error words
  assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_ERR |-> error_code == ERR_NO_QUOTE)
    else $error("error code set on a non-error word");

  // a non-final data word is followed by another data word of the same set
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> out_valid && kind == KIND_DATA)
    else $error("set of results broken off");

  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (.*);

`default_nettype wire
